@@ rtl/lkv_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
package lkv_pkg;

   // Widest rank or slot index over the supported depth range (up to 256 slots).
   localparam int RankMaxW = 8;

   localparam logic CmdGet = 1'b0;
   localparam logic CmdPut = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_type;

   // Broadcast from the controller to every slot cell.
   typedef struct packed {
      logic                promote;    // an update of recency takes place this cycle
      logic                store;      // target slot takes key and value
      logic                hit;        // target is the matching slot
      logic                evict;      // target is the least recent slot
      logic                age_all;    // every valid slot ages (fill of a free slot)
      logic [RankMaxW-1:0] age_below;  // slots ranked below this age by one
      logic [RankMaxW-1:0] evict_rank;
      logic [RankMaxW-1:0] free_idx;
      logic signed [31:0]  key;
      logic signed [31:0]  value;
   } cell_ctrl_type;

   // Match information passed from cell to cell along the row.
   typedef struct packed {
      logic                hit;
      logic [RankMaxW-1:0] rank;
      logic signed [31:0]  value;
   } cell_chain_type;

endpackage

@@ rtl/lkv_cell.sv @@
// One slot of the cache: key, value, valid flag and recency rank.
`timescale 1ns / 1ps
module lkv_cell #(
   parameter int Index = 0,
   parameter int RankW = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkv_pkg::cell_ctrl_type ctrl,
   input  lkv_pkg::cell_chain_type chain_in,
   output lkv_pkg::cell_chain_type chain_out
);
   import lkv_pkg::*;

   logic               valid_ff, valid_in;
   logic [RankW-1:0]   rank_ff, rank_in;
   logic signed [31:0] key_ff, key_in;
   logic signed [31:0] value_ff, value_in;
   logic               match;
   logic               target;
   logic [RankMaxW-1:0] rank_ext;

   assign rank_ext = RankMaxW'(rank_ff);
   assign match    = valid_ff && (key_ff == ctrl.key);

   always_comb begin
      chain_out.hit   = chain_in.hit | match;
      chain_out.rank  = chain_in.rank | (match ? rank_ext : '0);
      chain_out.value = chain_in.value | (match ? value_ff : '0);
   end

   always_comb begin
      if (ctrl.hit) begin
         target = match;
      end else if (ctrl.evict) begin
         target = valid_ff && (rank_ext == ctrl.evict_rank);
      end else begin
         target = (RankMaxW'(Index) == ctrl.free_idx);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.promote) begin
         if (target) begin
            valid_in = 1'b1;
            rank_in  = '0;
            if (ctrl.store) begin
               key_in   = ctrl.key;
               value_in = ctrl.value;
            end
         end else if (valid_ff && (ctrl.age_all || rank_ext < ctrl.age_below)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: slot row, occupancy and result register.
`timescale 1ns / 1ps
// Fully associative key/value cache with least-recently-used replacement, built as a
// row of ENTRIES slot cells. Every cell compares its key with the request at once and the
// match is passed along the row; a get or put is accepted each cycle with req_ready high
// and finishes in that cycle, the key compare, the match chain through all cells and the
// rank update making up its path. A get's result comes from an output register in the
// next cycle; a put gives none. req_ready drops only while a result waits on rsp_ready.
// Slots fill in index order and are never freed, so the free slot is the occupancy and
// the least recent one holds the rank occupancy-1. The capacity register (reset 16) is
// clamped to 1..ENTRIES and bounds occupancy; lowering it evicts nothing at once.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lkv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lkv_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);
   import lkv_pkg::*;

   localparam int RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OccW  = $clog2(ENTRIES + 1);
   localparam int CapW  = (OccW > 5) ? OccW : 5;

   logic [4:0]      capacity_ff, capacity_in;
   logic [OccW-1:0] occ_ff, occ_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic [CapW-1:0] cap_ext, eff_cap;
   logic [OccW-1:0] occ_m1;
   logic            accept, is_put, need_evict;
   cell_ctrl_type   ctrl;
   cell_chain_type  chain [ENTRIES+1];

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_put    = (req_data.cmd == CmdPut);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cap_ext = CapW'(capacity_ff);
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CapW'(1);
      end else if (cap_ext > CapW'(ENTRIES)) begin
         eff_cap = CapW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign need_evict = (CapW'(occ_ff) >= eff_cap);
   assign occ_m1     = occ_ff - 1'b1;

   assign chain[0] = '0;

   always_comb begin
      ctrl.promote    = accept && (chain[ENTRIES].hit || is_put);
      ctrl.store      = is_put;
      ctrl.hit        = chain[ENTRIES].hit;
      ctrl.evict      = need_evict;
      ctrl.age_all    = !chain[ENTRIES].hit && !need_evict;
      ctrl.evict_rank = RankMaxW'(occ_m1);
      ctrl.age_below  = chain[ENTRIES].hit ? chain[ENTRIES].rank : RankMaxW'(occ_m1);
      ctrl.free_idx   = RankMaxW'(occ_ff);
      ctrl.key        = req_data.key;
      ctrl.value      = req_data.value;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkv_cell #(
         .Index(i),
         .RankW(RankW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .chain_in (chain[i]),
         .chain_out(chain[i+1])
      );
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (accept && is_put && !chain[ENTRIES].hit && !need_evict) begin
         occ_in = occ_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && !is_put) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.found      = chain[ENTRIES].hit;
         rsp_data_in.read_value = chain[ENTRIES].value;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= 5'd16;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
